// ===== rtl/core/sc2a_pkg.sv =====
`timescale 1ns / 1ps

package sc2a_pkg;

	localparam logic [1:0] EvNone   = 2'd0;
	localparam logic [1:0] EvChar   = 2'd1;
	localparam logic [1:0] EvClear  = 2'd2;
	localparam logic [1:0] EvSwitch = 2'd3;

	localparam logic [7:0] KeyEnter    = 8'h1C;
	localparam logic [7:0] KeyTab      = 8'h0F;
	localparam logic [7:0] KeyEsc      = 8'h01;
	localparam logic [7:0] KeyAltDn    = 8'h38;
	localparam logic [7:0] KeyAltUp    = 8'hB8;
	localparam logic [7:0] KeyCapsDn   = 8'h3A;
	localparam logic [7:0] KeyCapsUp   = 8'hBA;
	localparam logic [7:0] KeyRshiftDn = 8'h36;
	localparam logic [7:0] KeyRshiftUp = 8'hB6;
	localparam logic [7:0] KeyLshiftDn = 8'h2A;
	localparam logic [7:0] KeyLshiftUp = 8'hAA;
	localparam logic [7:0] KeyCtrlDn   = 8'h1D;
	localparam logic [7:0] KeyCtrlUp   = 8'h9D;
	localparam logic [7:0] KeyL        = 8'h26;
	localparam logic [7:0] KeyF1       = 8'h3B;
	localparam logic [7:0] KeyF3       = 8'h3D;
	localparam logic [7:0] RelLo       = 8'h81;
	localparam logic [7:0] RelHi       = 8'hD8;
	localparam logic [7:0] PrintLo     = 8'h01;
	localparam logic [7:0] PrintHi     = 8'h39;
	localparam logic [7:0] LineFeed    = 8'h0A;

	localparam logic [7:0] LowerTbl [0:63] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h13, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] UpperTbl [0:63] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h13, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic caps_held;
		logic caps_active;
		logic right_shift_down;
		logic left_shift_down;
		logic ctrl_down;
		logic alt_down;
	} mod_state_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] char_code;
		logic [1:0] terminal_index;
	} result_t;

	function automatic logic letter_code(input logic [7:0] code);
		logic r;
		r = 1'b1;
		if (code inside {[8'h01:8'h0D], 8'h1A, 8'h1B, [8'h27:8'h2B], [8'h33:8'h35]}) begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/sc2a_decode.sv =====
`timescale 1ns / 1ps

module sc2a_decode import sc2a_pkg::*; (
	input  logic [7:0] code,
	input  mod_state_t state,
	output mod_state_t state_next,
	output result_t    res
);

	logic upper;

	always_comb begin
		state_next = state;
		res = '0;
		upper = state.right_shift_down | state.left_shift_down;
		if (code == KeyEnter) begin
			res.event_kind = EvChar;
			res.char_code = LineFeed;
		end else if (code == KeyTab || code == KeyEsc) begin
			// ignored
		end else if (code == KeyAltDn) begin
			state_next.alt_down = 1'b1;
		end else if (code == KeyAltUp) begin
			state_next.alt_down = 1'b0;
		end else if (code == KeyCapsDn) begin
			// auto-repeat leaves caps mode alone
			if (!state.caps_held) begin
				state_next.caps_active = ~state.caps_active;
				state_next.caps_held = 1'b1;
			end
		end else if (code == KeyCapsUp) begin
			state_next.caps_held = 1'b0;
		end else if (code == KeyRshiftDn) begin
			state_next.right_shift_down = 1'b1;
		end else if (code == KeyRshiftUp) begin
			state_next.right_shift_down = 1'b0;
		end else if (code == KeyLshiftDn) begin
			state_next.left_shift_down = 1'b1;
		end else if (code == KeyLshiftUp) begin
			state_next.left_shift_down = 1'b0;
		end else if (code == KeyCtrlDn) begin
			state_next.ctrl_down = 1'b1;
		end else if (code == KeyCtrlUp) begin
			state_next.ctrl_down = 1'b0;
		end else if (code inside {[RelLo:RelHi]}) begin
			// other releases ignored
		end else if (code inside {[PrintLo:PrintHi]} && !state.ctrl_down
				&& !state.alt_down) begin
			if (state.caps_active && letter_code(code)) begin
				upper = ~upper;
			end
			res.event_kind = EvChar;
			res.char_code = upper ? UpperTbl[code[5:0]] : LowerTbl[code[5:0]];
		end else if (code == KeyL && state.ctrl_down) begin
			res.event_kind = EvClear;
		end else if (state.alt_down && code inside {[KeyF1:KeyF3]}) begin
			res.event_kind = EvSwitch;
			res.terminal_index = 2'(code - KeyF1);
		end
	end

endmodule

// ===== rtl/core/scan_code_to_ascii_decoder.sv =====
`timescale 1ns / 1ps
// an input transfer is captured in the input register, then decoded into the result register, which drives out_valid
// throughput: one scan code per cycle while out_ready does not hold the result register
// a result waiting on out_ready blocks the next input transfer only while the input stage also holds a code
// reset (arst_n low, asynchronous): pipeline empty, all modifier and caps lock state cleared

module scan_code_to_ascii_decoder import sc2a_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] char_code,
	output logic [1:0] terminal_index
);

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       valid_s2;
	result_t    res_s2;
	mod_state_t state_q;
	mod_state_t state_next;
	result_t    res;
	logic       advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	sc2a_decode u_decode (
		.code       (code_s1),
		.state      (state_q),
		.state_next (state_next),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			// modifier state moves once per decoded transfer
			if (valid_s1 && advance) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= scan_code;
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign event_kind     = res_s2.event_kind;
	assign char_code      = res_s2.char_code;
	assign terminal_index = res_s2.terminal_index;

endmodule

// ===== dv/scan_decode_checker.sv =====
`timescale 1ns / 1ps

module scan_decode_checker import sc2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  scan_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  event_kind,
	input  logic [7:0]  char_code,
	input  logic [1:0]  terminal_index,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam logic [7:0] PlainChars [0:57] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h13, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	localparam logic [7:0] ShiftedChars [0:57] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h13, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	logic    caps_down;
	logic    caps_lock_on;
	logic    rshift_on;
	logic    lshift_on;
	logic    ctrl_on;
	logic    alt_on;
	result_t expected_events [$];
	result_t want;
	int unsigned errors;

	assign fail_count = errors;

	// caps lock only flips the case of letter keys
	function automatic logic is_letter_key(input logic [7:0] code);
		return !((code >= 8'h01 && code <= 8'h0D) || code == 8'h1A || code == 8'h1B ||
			(code >= 8'h27 && code <= 8'h2B) || (code >= 8'h33 && code <= 8'h35));
	endfunction

	function automatic result_t decode_scan_code(input logic [7:0] code);
		result_t r;
		logic    upper;
		r = '0;
		upper = 1'b0;
		if (code == KeyEnter) begin
			r.event_kind = EvChar;
			r.char_code = LineFeed;
		end else if (code == KeyTab || code == KeyEsc) begin
		end else if (code == KeyAltDn) begin
			alt_on = 1'b1;
		end else if (code == KeyAltUp) begin
			alt_on = 1'b0;
		end else if (code == KeyCapsDn) begin
			if (!caps_down) begin
				caps_lock_on = !caps_lock_on;
				caps_down = 1'b1;
			end
		end else if (code == KeyCapsUp) begin
			caps_down = 1'b0;
		end else if (code == KeyRshiftDn) begin
			rshift_on = 1'b1;
		end else if (code == KeyRshiftUp) begin
			rshift_on = 1'b0;
		end else if (code == KeyLshiftDn) begin
			lshift_on = 1'b1;
		end else if (code == KeyLshiftUp) begin
			lshift_on = 1'b0;
		end else if (code == KeyCtrlDn) begin
			ctrl_on = 1'b1;
		end else if (code == KeyCtrlUp) begin
			ctrl_on = 1'b0;
		end else if (code >= RelLo && code <= RelHi) begin
		end else if (code >= PrintLo && code <= PrintHi && !ctrl_on && !alt_on) begin
			upper = rshift_on || lshift_on;
			if (caps_lock_on && is_letter_key(code)) begin
				upper = !upper;
			end
			r.event_kind = EvChar;
			r.char_code = upper ? ShiftedChars[code] : PlainChars[code];
		end else if (code == KeyL && ctrl_on) begin
			r.event_kind = EvClear;
		end else if (alt_on && code >= KeyF1 && code <= KeyF3) begin
			r.event_kind = EvSwitch;
			r.terminal_index = 2'(code - KeyF1);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_down = 1'b0;
			caps_lock_on = 1'b0;
			rshift_on = 1'b0;
			lshift_on = 1'b0;
			ctrl_on = 1'b0;
			alt_on = 1'b0;
			expected_events.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("result transfer with nothing expected: event_kind %0d char_code %0h",
						event_kind, char_code);
					errors++;
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.event_kind) begin
						$error("event_kind: expected %0d, got %0d", want.event_kind, event_kind);
						errors++;
					end
					if (char_code !== want.char_code) begin
						$error("char_code: expected %0h, got %0h", want.char_code, char_code);
						errors++;
					end
					if (terminal_index !== want.terminal_index) begin
						$error("terminal_index: expected %0d, got %0d", want.terminal_index,
							terminal_index);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_events.push_back(decode_scan_code(scan_code));
			end
			pending <= expected_events.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb import sc2a_pkg::*; ();

	localparam int CycleLimit  = 100000;
	localparam int RandomItems = 1050;
	localparam int CalmItems   = 150;
	localparam int HoldStart   = 300;
	localparam int HoldItems   = 40;
	localparam int HoldCycles  = 100;
	localparam int WarmupLen   = 28;

	localparam logic [7:0] Warmup [0:WarmupLen-1] = '{
		8'h00, 8'hFF, 8'h10, KeyLshiftDn, 8'h10, 8'h02, KeyLshiftUp,
		KeyCapsDn, KeyCapsDn, 8'h10, 8'h02, KeyRshiftDn, 8'h10, KeyRshiftUp,
		KeyCapsUp, KeyCtrlDn, KeyL, KeyEnter, KeyCtrlUp, KeyAltDn, KeyF1,
		KeyF3, 8'h3E, KeyAltUp, RelLo, RelHi, KeyTab, KeyEsc
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  scan_code;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_kind;
	logic [7:0]  char_code;
	logic [1:0]  terminal_index;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned rx_steps;
	bit          calm;
	bit          hold_off_req;

	scan_code_to_ascii_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.scan_code      (scan_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.char_code      (char_code),
		.terminal_index (terminal_index)
	);

	scan_decode_checker decode_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.scan_code      (scan_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.char_code      (char_code),
		.terminal_index (terminal_index),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("** scan_code_to_ascii_decoder: FAILED **");
				$finish;
			end
		end
	end

	// mostly keystrokes with modifier presses and releases, plus noise
	function automatic logic [7:0] pick_keystroke();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 42) begin
			return 8'($urandom_range(PrintLo, PrintHi));
		end else if (roll < 50) begin
			case ($urandom_range(0, 3))
				0: return KeyLshiftDn;
				1: return KeyLshiftUp;
				2: return KeyRshiftDn;
				default: return KeyRshiftUp;
			endcase
		end else if (roll < 56) begin
			return ($urandom_range(0, 3) == 0) ? KeyCtrlDn : KeyCtrlUp;
		end else if (roll < 62) begin
			return ($urandom_range(0, 3) == 0) ? KeyAltDn : KeyAltUp;
		end else if (roll < 67) begin
			return $urandom_range(0, 1) ? KeyCapsDn : KeyCapsUp;
		end else if (roll < 74) begin
			return 8'($urandom_range(RelLo, RelHi));
		end else if (roll < 80) begin
			return 8'($urandom_range(KeyF1, KeyF3 + 8'd1));
		end else if (roll < 84) begin
			return KeyL;
		end else if (roll < 88) begin
			case ($urandom_range(0, 2))
				0: return KeyEnter;
				1: return KeyTab;
				default: return KeyEsc;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int unsigned pick_idle_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_scan_code(input logic [7:0] code);
		in_valid <= 1'b1;
		scan_code <= code;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver side
	initial begin
		out_ready = 1'b0;
		stall_pct = 0;
		rx_steps = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_steps % 64 == 0) begin
				stall_pct = pick_idle_rate();
			end
			rx_steps++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		scan_code = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		gap_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < WarmupLen; i++) begin
			send_scan_code(Warmup[i]);
		end

		for (int i = 0; i < RandomItems; i++) begin
			if (i % 64 == 0) begin
				gap_pct = pick_idle_rate();
			end
			if (i == HoldStart) begin
				hold_off_req = 1'b1;
			end
			if (i == RandomItems - CalmItems) begin
				calm = 1'b1;
			end
			send_scan_code(pick_keystroke());
			if (!calm && !(i >= HoldStart && i < HoldStart + HoldItems) &&
				$urandom_range(0, 99) < gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("** scan_code_to_ascii_decoder: PASSED **");
		end else begin
			$display("** scan_code_to_ascii_decoder: FAILED **");
		end
		$finish;
	end

endmodule
